// ----- rtl/go_back_n_sender_window_defines.svh -----
// assertion helpers shared by the go-back-n sender window
`ifndef GO_BACK_N_SENDER_WINDOW_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_DEFINES_SVH

// same-cycle implication
`define GBN_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GBN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gbn_pkg.sv -----
package gbn_pkg;

  localparam int MAX_WINDOW  = 32;
  localparam int INDEX_BITS  = 21;
  localparam int SEQ_BITS    = 32;
  localparam int WIN_BITS    = 6;
  localparam int DPC_BITS    = 20;
  localparam int DUP_BITS    = 4;
  localparam int KIND_BITS   = 2;
  localparam int ADDR_BITS   = 4;
  localparam int DATA_BITS   = 32;
  localparam int REMAIN_BITS = $clog2(MAX_WINDOW + 1);

  localparam logic [KIND_BITS-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_NEW  = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_RETX = 2'd2;

  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_ACK  = 1'b1;

  localparam logic [1:0] REG_WINDOW_SIZE   = 2'd0;
  localparam logic [1:0] REG_PACKET_COUNT  = 2'd1;
  localparam logic [1:0] REG_SEQ_OFFSET    = 2'd2;
  localparam logic [1:0] REG_DUP_THRESHOLD = 2'd3;

  localparam logic [WIN_BITS-1:0] WINDOW_SIZE_RST   = 6'd8;
  localparam logic [DUP_BITS-1:0] DUP_THRESHOLD_RST = 4'd3;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SND_WIN,
    ST_SND_WCMP,
    ST_SND_DCMP,
    ST_SND_SEQ,
    ST_SND_INC,
    ST_EMIT0,
    ST_ACK_DIST,
    ST_ACK_GE,
    ST_ACK_LT,
    ST_ACK_SLIDE,
    ST_ACK_FIN,
    ST_ACK_DUP,
    ST_ACK_CNT,
    ST_ACK_THR,
    ST_ACK_SPAN,
    ST_BEAT
  } state_t;

  typedef struct packed {
    logic [WIN_BITS-1:0] window_size;
    logic [DPC_BITS-1:0] data_packet_count;
    logic [SEQ_BITS-1:0] seq_offset;
    logic [DUP_BITS-1:0] dup_threshold;
  } cfg_t;

  // sum = a + (inv ? ~b : b) + cin
  typedef struct packed {
    logic [SEQ_BITS-1:0] a;
    logic [SEQ_BITS-1:0] b;
    logic                inv;
    logic                cin;
  } alu_req_t;

  typedef struct packed {
    logic [SEQ_BITS-1:0] sum;
    logic                carry;
    logic                zero;
  } alu_rsp_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] window_base;
    logic [INDEX_BITS-1:0] next_index;
    logic                  finished;
  } stat_t;

endpackage

// ----- rtl/go_back_n_sender_window.sv -----
// the block takes no new transaction until it is back in idle from the last one (cmd_stall)
// the comparison and sequence-number steps go through one shared 32-bit adder/comparator stepped by the sequencer
// a retransmit burst gives one result per cycle while the output is not stalled
// reset (synchronous): window base and next index to 1, ack history and done flag cleared,
// configuration back to window 8, no packets, offset 0, threshold 3
`include "go_back_n_sender_window_defines.svh"

module go_back_n_sender_window (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gbn_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [gbn_pkg::DATA_BITS-1:0]   pwdata,
  output logic [gbn_pkg::DATA_BITS-1:0]   prdata,
  output logic                            pready,
  input  logic                            cmd_valid,
  output logic                            cmd_stall,
  input  logic                            command,
  input  logic [gbn_pkg::SEQ_BITS-1:0]    ack_num,
  input  logic                            ack_ok,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic [gbn_pkg::KIND_BITS-1:0]   kind,
  output logic [gbn_pkg::INDEX_BITS-1:0]  packet_index,
  output logic [gbn_pkg::SEQ_BITS-1:0]    seq_num,
  output logic                            done_res,
  output logic                            last
);

  gbn_pkg::cfg_t     cfg;
  gbn_pkg::alu_req_t alu_req;
  gbn_pkg::alu_rsp_t alu_rsp;
  gbn_pkg::stat_t    stat;
  logic              cfg_write;
  logic [1:0]        reg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_size       <= gbn_pkg::WINDOW_SIZE_RST;
      cfg.data_packet_count <= '0;
      cfg.seq_offset        <= '0;
      cfg.dup_threshold     <= gbn_pkg::DUP_THRESHOLD_RST;
    end else if (cfg_write) begin
      unique case (reg_sel)
        gbn_pkg::REG_WINDOW_SIZE:
          cfg.window_size <= pwdata[gbn_pkg::WIN_BITS-1:0];
        gbn_pkg::REG_PACKET_COUNT:
          cfg.data_packet_count <= pwdata[gbn_pkg::DPC_BITS-1:0];
        gbn_pkg::REG_SEQ_OFFSET:
          cfg.seq_offset <= pwdata[gbn_pkg::SEQ_BITS-1:0];
        gbn_pkg::REG_DUP_THRESHOLD:
          cfg.dup_threshold <= pwdata[gbn_pkg::DUP_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      gbn_pkg::REG_WINDOW_SIZE:   prdata = gbn_pkg::DATA_BITS'(cfg.window_size);
      gbn_pkg::REG_PACKET_COUNT:  prdata = gbn_pkg::DATA_BITS'(cfg.data_packet_count);
      gbn_pkg::REG_SEQ_OFFSET:    prdata = gbn_pkg::DATA_BITS'(cfg.seq_offset);
      gbn_pkg::REG_DUP_THRESHOLD: prdata = gbn_pkg::DATA_BITS'(cfg.dup_threshold);
      default:                    prdata = '0;
    endcase
  end

  gbn_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  gbn_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .command      (command),
    .ack_num      (ack_num),
    .ack_ok       (ack_ok),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .kind         (kind),
    .packet_index (packet_index),
    .seq_num      (seq_num),
    .done_res     (done_res),
    .last         (last),
    .alu_req      (alu_req),
    .alu_rsp      (alu_rsp),
    .stat         (stat)
  );

  `GBN_ASSERT_SAME(a_none_is_empty, clk, rst, res_valid && kind == gbn_pkg::KIND_NONE, packet_index == '0 && seq_num == '0, "no-packet result carries an index")
  `GBN_ASSERT_NEXT(a_busy_after_take, clk, rst, cmd_valid && !cmd_stall, cmd_stall, "transaction taken but block not busy")
  `GBN_ASSERT_SAME(a_base_le_next, clk, rst, 1'b1, stat.window_base <= stat.next_index, "window base passed next index")
  `GBN_ASSERT_NEXT(a_done_sticky, clk, rst, stat.finished, stat.finished, "done flag cleared")

endmodule

// ----- rtl/gbn_alu.sv -----
module gbn_alu (
  input  gbn_pkg::alu_req_t req,
  output gbn_pkg::alu_rsp_t rsp
);

  logic [gbn_pkg::SEQ_BITS-1:0] b_eff;
  logic [gbn_pkg::SEQ_BITS:0]   total;

  assign b_eff = req.inv ? ~req.b : req.b;
  assign total = {1'b0, req.a} + {1'b0, b_eff} + {{gbn_pkg::SEQ_BITS{1'b0}}, req.cin};

  assign rsp.sum   = total[gbn_pkg::SEQ_BITS-1:0];
  assign rsp.carry = total[gbn_pkg::SEQ_BITS];
  assign rsp.zero  = (total[gbn_pkg::SEQ_BITS-1:0] == '0);

endmodule

// ----- rtl/gbn_ctrl.sv -----
module gbn_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  gbn_pkg::cfg_t                    cfg,
  input  logic                             cmd_valid,
  output logic                             cmd_stall,
  input  logic                             command,
  input  logic [gbn_pkg::SEQ_BITS-1:0]     ack_num,
  input  logic                             ack_ok,
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic [gbn_pkg::KIND_BITS-1:0]    kind,
  output logic [gbn_pkg::INDEX_BITS-1:0]   packet_index,
  output logic [gbn_pkg::SEQ_BITS-1:0]     seq_num,
  output logic                             done_res,
  output logic                             last,
  output gbn_pkg::alu_req_t                alu_req,
  input  gbn_pkg::alu_rsp_t                alu_rsp,
  output gbn_pkg::stat_t                   stat
);

  gbn_pkg::state_t state, state_next;

  logic [gbn_pkg::INDEX_BITS-1:0]  window_base;
  logic [gbn_pkg::INDEX_BITS-1:0]  next_index;
  logic [gbn_pkg::SEQ_BITS-1:0]    last_ack;
  logic [gbn_pkg::DUP_BITS-1:0]    dup_count;
  logic                            finished;
  logic [gbn_pkg::SEQ_BITS-1:0]    ack_hold;
  logic [gbn_pkg::SEQ_BITS-1:0]    scratch;
  logic                            hit;
  logic [gbn_pkg::INDEX_BITS-1:0]  cur;
  logic [gbn_pkg::REMAIN_BITS-1:0] remain;

  logic                         out_free;
  logic                         emit;
  logic [gbn_pkg::WIN_BITS-1:0] win;
  logic                         span_big;

  assign out_free = !res_valid || !res_stall;
  assign emit     = out_free && (state == gbn_pkg::ST_SND_SEQ || state == gbn_pkg::ST_EMIT0 ||
                                 state == gbn_pkg::ST_BEAT);
  assign win = (cfg.window_size > gbn_pkg::WIN_BITS'(gbn_pkg::MAX_WINDOW)) ?
               gbn_pkg::WIN_BITS'(gbn_pkg::MAX_WINDOW) : cfg.window_size;
  assign span_big = (alu_rsp.sum > gbn_pkg::SEQ_BITS'(gbn_pkg::MAX_WINDOW));

  assign stat.window_base = window_base;
  assign stat.next_index  = next_index;
  assign stat.finished    = finished;

  always_comb begin
    state_next = state;
    unique case (state)
      gbn_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          if (command == gbn_pkg::CMD_SEND) begin
            state_next = gbn_pkg::ST_SND_WIN;
          end else if (!ack_ok || finished) begin
            state_next = gbn_pkg::ST_EMIT0;
          end else begin
            state_next = gbn_pkg::ST_ACK_DIST;
          end
        end
      end
      gbn_pkg::ST_SND_WIN:  state_next = gbn_pkg::ST_SND_WCMP;
      gbn_pkg::ST_SND_WCMP: begin
        // next_index < base + window
        if (!finished && !alu_rsp.carry) begin
          state_next = gbn_pkg::ST_SND_DCMP;
        end else begin
          state_next = gbn_pkg::ST_EMIT0;
        end
      end
      gbn_pkg::ST_SND_DCMP: begin
        // next_index <= packet count + 1
        if (!alu_rsp.carry || alu_rsp.zero) begin
          state_next = gbn_pkg::ST_SND_SEQ;
        end else begin
          state_next = gbn_pkg::ST_EMIT0;
        end
      end
      gbn_pkg::ST_SND_SEQ: begin
        if (out_free) begin
          state_next = gbn_pkg::ST_SND_INC;
        end
      end
      gbn_pkg::ST_SND_INC:  state_next = gbn_pkg::ST_IDLE;
      gbn_pkg::ST_EMIT0: begin
        if (out_free) begin
          state_next = gbn_pkg::ST_IDLE;
        end
      end
      gbn_pkg::ST_ACK_DIST: state_next = gbn_pkg::ST_ACK_GE;
      gbn_pkg::ST_ACK_GE:   state_next = gbn_pkg::ST_ACK_LT;
      gbn_pkg::ST_ACK_LT: begin
        if (hit && !alu_rsp.carry) begin
          state_next = gbn_pkg::ST_ACK_SLIDE;
        end else begin
          state_next = gbn_pkg::ST_ACK_FIN;
        end
      end
      gbn_pkg::ST_ACK_SLIDE: state_next = gbn_pkg::ST_ACK_FIN;
      gbn_pkg::ST_ACK_FIN: begin
        if (alu_rsp.zero) begin
          state_next = gbn_pkg::ST_EMIT0;
        end else begin
          state_next = gbn_pkg::ST_ACK_DUP;
        end
      end
      gbn_pkg::ST_ACK_DUP: begin
        if (alu_rsp.zero) begin
          state_next = gbn_pkg::ST_ACK_CNT;
        end else begin
          state_next = gbn_pkg::ST_EMIT0;
        end
      end
      gbn_pkg::ST_ACK_CNT: state_next = gbn_pkg::ST_ACK_THR;
      gbn_pkg::ST_ACK_THR: begin
        if (alu_rsp.carry) begin
          state_next = gbn_pkg::ST_ACK_SPAN;
        end else begin
          state_next = gbn_pkg::ST_EMIT0;
        end
      end
      gbn_pkg::ST_ACK_SPAN: begin
        if (alu_rsp.carry && !alu_rsp.zero) begin
          state_next = gbn_pkg::ST_BEAT;
        end else begin
          state_next = gbn_pkg::ST_EMIT0;
        end
      end
      gbn_pkg::ST_BEAT: begin
        if (out_free && remain == gbn_pkg::REMAIN_BITS'(1)) begin
          state_next = gbn_pkg::ST_IDLE;
        end
      end
      default: state_next = gbn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_stall   = (state != gbn_pkg::ST_IDLE);
    alu_req     = '0;
    unique case (state)
      gbn_pkg::ST_SND_WIN: begin
        alu_req.a = gbn_pkg::SEQ_BITS'(window_base);
        alu_req.b = gbn_pkg::SEQ_BITS'(win);
      end
      gbn_pkg::ST_SND_WCMP: begin
        alu_req.a   = gbn_pkg::SEQ_BITS'(next_index);
        alu_req.b   = scratch;
        alu_req.inv = 1'b1;
        alu_req.cin = 1'b1;
      end
      gbn_pkg::ST_SND_DCMP: begin
        // a - b - 1: zero when a == b + 1
        alu_req.a   = gbn_pkg::SEQ_BITS'(next_index);
        alu_req.b   = gbn_pkg::SEQ_BITS'(cfg.data_packet_count);
        alu_req.inv = 1'b1;
      end
      gbn_pkg::ST_SND_SEQ: begin
        alu_req.a = cfg.seq_offset;
        alu_req.b = gbn_pkg::SEQ_BITS'(next_index);
      end
      gbn_pkg::ST_SND_INC: begin
        alu_req.a   = gbn_pkg::SEQ_BITS'(next_index);
        alu_req.cin = 1'b1;
      end
      gbn_pkg::ST_ACK_DIST: begin
        alu_req.a   = ack_hold;
        alu_req.b   = cfg.seq_offset;
        alu_req.inv = 1'b1;
        alu_req.cin = 1'b1;
      end
      gbn_pkg::ST_ACK_GE: begin
        alu_req.a   = scratch;
        alu_req.b   = gbn_pkg::SEQ_BITS'(window_base);
        alu_req.inv = 1'b1;
        alu_req.cin = 1'b1;
      end
      gbn_pkg::ST_ACK_LT: begin
        alu_req.a   = scratch;
        alu_req.b   = gbn_pkg::SEQ_BITS'(next_index);
        alu_req.inv = 1'b1;
        alu_req.cin = 1'b1;
      end
      gbn_pkg::ST_ACK_SLIDE: begin
        alu_req.a   = scratch;
        alu_req.cin = 1'b1;
      end
      gbn_pkg::ST_ACK_FIN: begin
        alu_req.a   = scratch;
        alu_req.b   = gbn_pkg::SEQ_BITS'(cfg.data_packet_count);
        alu_req.inv = 1'b1;
      end
      gbn_pkg::ST_ACK_DUP: begin
        alu_req.a   = ack_hold;
        alu_req.b   = last_ack;
        alu_req.inv = 1'b1;
        alu_req.cin = 1'b1;
      end
      gbn_pkg::ST_ACK_CNT: begin
        alu_req.a   = gbn_pkg::SEQ_BITS'(dup_count);
        alu_req.cin = 1'b1;
      end
      gbn_pkg::ST_ACK_THR: begin
        alu_req.a   = gbn_pkg::SEQ_BITS'(dup_count);
        alu_req.b   = gbn_pkg::SEQ_BITS'(cfg.dup_threshold);
        alu_req.inv = 1'b1;
        alu_req.cin = 1'b1;
      end
      gbn_pkg::ST_ACK_SPAN: begin
        alu_req.a   = gbn_pkg::SEQ_BITS'(next_index);
        alu_req.b   = gbn_pkg::SEQ_BITS'(window_base);
        alu_req.inv = 1'b1;
        alu_req.cin = 1'b1;
      end
      gbn_pkg::ST_BEAT: begin
        alu_req.a = cfg.seq_offset;
        alu_req.b = gbn_pkg::SEQ_BITS'(cur);
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= gbn_pkg::ST_IDLE;
      window_base <= gbn_pkg::INDEX_BITS'(1);
      next_index  <= gbn_pkg::INDEX_BITS'(1);
      last_ack    <= '0;
      dup_count   <= '0;
      finished    <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        gbn_pkg::ST_IDLE: begin
          if (cmd_valid) begin
            ack_hold <= ack_num;
          end
        end
        gbn_pkg::ST_SND_WIN: scratch <= alu_rsp.sum;
        gbn_pkg::ST_SND_SEQ: begin
          if (out_free) begin
            kind         <= gbn_pkg::KIND_NEW;
            packet_index <= next_index;
            seq_num      <= alu_rsp.sum;
            done_res     <= finished;
            last         <= 1'b1;
          end
        end
        gbn_pkg::ST_SND_INC: next_index <= alu_rsp.sum[gbn_pkg::INDEX_BITS-1:0];
        gbn_pkg::ST_EMIT0: begin
          if (out_free) begin
            kind         <= gbn_pkg::KIND_NONE;
            packet_index <= '0;
            seq_num      <= '0;
            done_res     <= finished;
            last         <= 1'b1;
          end
        end
        gbn_pkg::ST_ACK_DIST:  scratch <= alu_rsp.sum;
        gbn_pkg::ST_ACK_GE:    hit <= alu_rsp.carry;
        gbn_pkg::ST_ACK_SLIDE: window_base <= alu_rsp.sum[gbn_pkg::INDEX_BITS-1:0];
        gbn_pkg::ST_ACK_FIN: begin
          if (alu_rsp.zero) begin
            finished <= 1'b1;
          end
        end
        gbn_pkg::ST_ACK_DUP: begin
          if (!alu_rsp.zero) begin
            last_ack  <= ack_hold;
            dup_count <= '0;
          end
        end
        gbn_pkg::ST_ACK_CNT: dup_count <= alu_rsp.sum[gbn_pkg::DUP_BITS-1:0];
        gbn_pkg::ST_ACK_THR: begin
          if (alu_rsp.carry) begin
            dup_count <= '0;
          end
        end
        gbn_pkg::ST_ACK_SPAN: begin
          // burst length capped at the largest window
          cur    <= window_base;
          remain <= span_big ? gbn_pkg::REMAIN_BITS'(gbn_pkg::MAX_WINDOW) :
                               alu_rsp.sum[gbn_pkg::REMAIN_BITS-1:0];
        end
        gbn_pkg::ST_BEAT: begin
          if (out_free) begin
            kind         <= gbn_pkg::KIND_RETX;
            packet_index <= cur;
            seq_num      <= alu_rsp.sum;
            done_res     <= finished;
            last         <= (remain == gbn_pkg::REMAIN_BITS'(1));
            cur          <= cur + gbn_pkg::INDEX_BITS'(1);
            remain       <= remain - gbn_pkg::REMAIN_BITS'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
